/* rtl/core/kfli_pkg.sv */
// ---------------------------------------------------------------------------
// kfli_pkg
// Types, constants and command structs shared by the keyframe interpolator.
// ---------------------------------------------------------------------------
package kfli_pkg;

  localparam int MaxKeys  = 16;
  localparam int FracBits = 16;
  localparam int IdxW     = $clog2(MaxKeys);
  localparam int CntW     = $clog2(MaxKeys + 1);
  localparam int UW       = FracBits + 1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SPAN = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_QUERY  = 1'b1;

  localparam logic [1:0] EM_LINEAR = 2'd0;
  localparam logic [1:0] EM_SPLINE = 2'd1;
  localparam logic [1:0] EM_ACCEL  = 2'd2;
  localparam logic [1:0] EM_DECEL  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_SCAN, S_INS_SHIFT, S_INS_WRITE,
    S_Q_SCAN, S_Q_RD_S, S_Q_RD_E, S_Q_DIV, S_Q_EASE1, S_Q_EASE2, S_Q_SQRT,
    S_Q_BLEND, S_DONE
  } state_t;

  typedef struct packed {
    logic             scan_clr;   // reset scan index to 0
    logic             scan_inc;
    logic             shift_dec;  // move shift index down
    logic             rd_scan;    // read memory at the incremented scan index
    logic             rd_shift;   // read memory at shift index - 1
    logic             wr_shift;   // write shifted entry
    logic             wr_new;     // write new key at scan index
    logic             cnt_inc;
    logic             rd_start;   // read at scan index - 1
    logic             rd_end;     // read at scan index
    logic             span_setup;
    logic             div_step;
    logic             ease1;
    logic             ease2;
    logic             sqrt_step;
    logic             blend;
    logic             res_ins;
    logic             res_full;
    logic             res_miss;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;     // t < time at scan index
    logic scan_end;     // scan index == count
    logic scan_first;   // scan index == 0
    logic full;
    logic shift_done;   // shift index == scan index
    logic iter_done;
    logic [1:0] mode;
  } sts_t;

endpackage

/* rtl/core/kfli_ctrl.sv */
// ---------------------------------------------------------------------------
// kfli_ctrl
// Sequencer for insert and query operations.
// ---------------------------------------------------------------------------
module kfli_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            func,
  input  logic            out_free,
  input  kfli_pkg::sts_t  sts,
  output kfli_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  kfli_pkg::state_t state, state_next;
  logic             mem_wait, mem_wait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kfli_pkg::S_IDLE;
      mem_wait <= 1'b0;
    end else begin
      state    <= state_next;
      mem_wait <= mem_wait_next;
    end
  end

  // mem_wait: a read issued, data arrives next cycle
  always_comb begin
    state_next    = state;
    mem_wait_next = 1'b0;
    case (state)
      kfli_pkg::S_IDLE: begin
        if (start) begin
          if (func == kfli_pkg::FN_INSERT)
            state_next = sts.full ? kfli_pkg::S_DONE : kfli_pkg::S_INS_SCAN;
          else
            state_next = kfli_pkg::S_Q_SCAN;
          mem_wait_next = 1'b1;
        end
      end
      kfli_pkg::S_INS_SCAN: begin
        if (mem_wait) mem_wait_next = 1'b0;
        else if (sts.scan_end || sts.scan_hit)
          state_next = sts.shift_done ? kfli_pkg::S_INS_WRITE : kfli_pkg::S_INS_SHIFT;
        else mem_wait_next = 1'b1;
      end
      // shift: write phase, then index check and next read
      kfli_pkg::S_INS_SHIFT: begin
        if (!mem_wait) mem_wait_next = 1'b1;
        else if (sts.shift_done) state_next = kfli_pkg::S_INS_WRITE;
      end
      kfli_pkg::S_INS_WRITE: state_next = kfli_pkg::S_DONE;
      kfli_pkg::S_Q_SCAN: begin
        if (mem_wait) mem_wait_next = 1'b0;
        else if (sts.scan_end) state_next = kfli_pkg::S_DONE;
        else if (sts.scan_hit) begin
          if (sts.scan_first) state_next = kfli_pkg::S_DONE;
          else begin
            state_next    = kfli_pkg::S_Q_RD_S;
            mem_wait_next = 1'b1;
          end
        end else mem_wait_next = 1'b1;
      end
      kfli_pkg::S_Q_RD_S: begin
        state_next    = kfli_pkg::S_Q_RD_E;
        mem_wait_next = 1'b1;
      end
      kfli_pkg::S_Q_RD_E: if (!mem_wait) state_next = kfli_pkg::S_Q_DIV;
      kfli_pkg::S_Q_DIV:  if (sts.iter_done) state_next = kfli_pkg::S_Q_EASE1;
      kfli_pkg::S_Q_EASE1: state_next = (sts.mode == kfli_pkg::EM_DECEL) ?
                                        kfli_pkg::S_Q_SQRT : kfli_pkg::S_Q_EASE2;
      kfli_pkg::S_Q_EASE2: state_next = kfli_pkg::S_Q_BLEND;
      kfli_pkg::S_Q_SQRT:  if (sts.iter_done) state_next = kfli_pkg::S_Q_BLEND;
      kfli_pkg::S_Q_BLEND: begin
        if (mem_wait) state_next = kfli_pkg::S_DONE;
        else mem_wait_next = 1'b1;
      end
      kfli_pkg::S_DONE:    if (out_free) state_next = kfli_pkg::S_IDLE;
      default:             state_next = kfli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != kfli_pkg::S_IDLE);
    done = 1'b0;
    case (state)
      kfli_pkg::S_IDLE: begin
        if (start) begin
          cmd.scan_clr = 1'b1;
          cmd.res_full = (func == kfli_pkg::FN_INSERT) && sts.full;
        end
      end
      kfli_pkg::S_INS_SCAN: begin
        if (!mem_wait) begin
          if (sts.scan_end || sts.scan_hit) begin
            if (!sts.shift_done) cmd.rd_shift = 1'b1;
          end else begin
            cmd.scan_inc = 1'b1;
            cmd.rd_scan  = 1'b1;
          end
        end
      end
      kfli_pkg::S_INS_SHIFT: begin
        if (!mem_wait) begin
          cmd.wr_shift  = 1'b1;
          cmd.shift_dec = 1'b1;
        end else if (!sts.shift_done) cmd.rd_shift = 1'b1;
      end
      kfli_pkg::S_INS_WRITE: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.res_ins = 1'b1;
      end
      kfli_pkg::S_Q_SCAN: begin
        if (!mem_wait) begin
          if (sts.scan_end || (sts.scan_hit && sts.scan_first)) cmd.res_miss = 1'b1;
          else if (sts.scan_hit) cmd.rd_start = 1'b1;
          else begin
            cmd.scan_inc = 1'b1;
            cmd.rd_scan  = 1'b1;
          end
        end
      end
      kfli_pkg::S_Q_RD_S:  cmd.rd_end = 1'b1;
      kfli_pkg::S_Q_RD_E:  if (!mem_wait) cmd.span_setup = 1'b1;
      kfli_pkg::S_Q_DIV:   cmd.div_step = !sts.iter_done;
      kfli_pkg::S_Q_EASE1: cmd.ease1 = 1'b1;
      kfli_pkg::S_Q_EASE2: cmd.ease2 = 1'b1;
      kfli_pkg::S_Q_SQRT:  cmd.sqrt_step = !sts.iter_done;
      kfli_pkg::S_Q_BLEND: cmd.blend = !mem_wait;
      kfli_pkg::S_DONE:    done = 1'b1;
      default: ;
    endcase
  end

endmodule

/* rtl/core/kfli_dp.sv */
// ---------------------------------------------------------------------------
// kfli_dp
// Key table memory, scan/shift indexes, divider, easing, root and blend.
// ---------------------------------------------------------------------------
module kfli_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic signed [31:0]   in_time,
  input  logic signed [31:0]   in_x,
  input  logic signed [31:0]   in_y,
  input  logic signed [31:0]   in_z,
  input  logic [1:0]           in_mode,
  input  kfli_pkg::cmd_t       cmd,
  output kfli_pkg::sts_t       sts,
  output logic [1:0]           res_status,
  output logic [4:0]           res_slot,
  output logic signed [31:0]   res_x,
  output logic signed [31:0]   res_y,
  output logic signed [31:0]   res_z
);

  localparam int EntW = 32 * 4 + 2;
  localparam int SqW  = 2 * kfli_pkg::UW;

  logic [EntW-1:0]           mem [kfli_pkg::MaxKeys];
  logic [EntW-1:0]           rd_data;
  logic [kfli_pkg::CntW-1:0] key_count;
  logic [kfli_pkg::CntW-1:0] scan_idx;
  logic [kfli_pkg::CntW-1:0] shift_idx;
  logic signed [31:0]        t_reg;
  logic [EntW-1:0]           new_ent;
  logic [EntW-1:0]           ent_s;
  logic [1:0]                mode_e;

  logic [32:0]               span;
  logic [32:0]               rem;
  logic [kfli_pkg::UW-1:0]   quo;
  logic [5:0]                iter;
  logic [kfli_pkg::UW-1:0]   u;
  logic [SqW-1:0]            sq;
  logic [kfli_pkg::UW-1:0]   ew;
  logic [SqW+1:0]            sq_rem;
  logic [kfli_pkg::UW:0]     root;
  logic signed [32:0]        dif_x, dif_y, dif_z;

  logic signed [31:0] st_time;
  assign st_time = rd_data[31:0];

  assign sts.scan_hit   = (t_reg < st_time);
  assign sts.scan_end   = (scan_idx == key_count);
  assign sts.scan_first = (scan_idx == '0);
  assign sts.full       = (key_count >= kfli_pkg::CntW'(kfli_pkg::MaxKeys));
  assign sts.shift_done = (shift_idx == scan_idx);
  assign sts.iter_done  = (iter == 6'd0);
  assign sts.mode       = mode_e;

  logic [kfli_pkg::IdxW-1:0] rd_addr;
  always_comb begin
    rd_addr = scan_idx[kfli_pkg::IdxW-1:0];
    if (cmd.rd_shift || cmd.rd_start)
      rd_addr = kfli_pkg::IdxW'((cmd.rd_shift ? shift_idx : scan_idx) - 1'b1);
    else if (cmd.scan_inc)
      rd_addr = kfli_pkg::IdxW'(scan_idx + 1'b1);
  end

  // first read of a scan uses address 0 at load
  logic rd_en;
  assign rd_en = load || cmd.rd_scan || cmd.rd_shift || cmd.rd_start || cmd.rd_end;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[load ? '0 : rd_addr];
    if (cmd.wr_shift) mem[shift_idx[kfli_pkg::IdxW-1:0]] <= rd_data;
    if (cmd.wr_new)   mem[scan_idx[kfli_pkg::IdxW-1:0]] <= new_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) key_count <= '0;
    else if (cmd.cnt_inc) key_count <= key_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      t_reg   <= in_time;
      new_ent <= {in_mode, in_z, in_y, in_x, in_time};
    end
    if (cmd.scan_clr) begin
      scan_idx  <= '0;
      shift_idx <= key_count;
    end else if (cmd.scan_inc) scan_idx <= scan_idx + 1'b1;
    if (cmd.shift_dec) shift_idx <= shift_idx - 1'b1;
    if (cmd.rd_end) ent_s <= rd_data;
  end

  // span, divide, ease, root, blend
  logic signed [32:0] span_w, d_w;
  always_comb begin
    span_w = $signed({rd_data[31], rd_data[31:0]}) - $signed({ent_s[31], ent_s[31:0]});
    d_w    = $signed({t_reg[31], t_reg}) - $signed({ent_s[31], ent_s[31:0]});
  end

  logic signed [kfli_pkg::UW+33:0] pr_x, pr_y, pr_z;
  function automatic logic signed [31:0] blend_f(input logic signed [31:0] a,
                                                 input logic signed [kfli_pkg::UW+33:0] p);
    logic signed [kfli_pkg::UW+33:0] q;
    begin
      q = p >>> kfli_pkg::FracBits;
      blend_f = 32'(a + q);
    end
  endfunction
  assign pr_x = $signed({1'b0, ew}) * dif_x;
  assign pr_y = $signed({1'b0, ew}) * dif_y;
  assign pr_z = $signed({1'b0, ew}) * dif_z;

  logic [SqW-1:0]           sq_w;
  logic [SqW+kfli_pkg::UW:0] sp_w;
  logic [kfli_pkg::UW+1:0]  k_w;
  assign sq_w = u * u;
  assign k_w  = (kfli_pkg::UW+2)'(3) << kfli_pkg::FracBits;
  assign sp_w = sq[kfli_pkg::UW-1:0] * (k_w - {u, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.span_setup) begin
      span   <= span_w;
      mode_e <= rd_data[EntW-1 -: 2];
      dif_x  <= $signed({rd_data[63], rd_data[63:32]})  - $signed({ent_s[63], ent_s[63:32]});
      dif_y  <= $signed({rd_data[95], rd_data[95:64]})  - $signed({ent_s[95], ent_s[95:64]});
      dif_z  <= $signed({rd_data[127], rd_data[127:96]}) - $signed({ent_s[127], ent_s[127:96]});
      rem    <= '0;
      // dividend d << FracBits fed one bit a step, MSB first
      quo    <= '0;
      sq_rem <= {{(SqW+2-33){1'b0}}, (d_w < 0) ? 33'd0 : ((d_w > span_w) ? span_w : d_w)};
      iter   <= 6'(33 + kfli_pkg::FracBits);
    end else if (cmd.div_step) begin
      // restoring divide: shift in dividend bits (d then zeros)
      logic [33:0] r2;
      r2 = {rem, sq_rem[32]};
      if (r2 >= {1'b0, span}) begin
        rem <= 33'(r2 - {1'b0, span});
        quo <= {quo[kfli_pkg::UW-2:0], 1'b1};
      end else begin
        rem <= r2[32:0];
        quo <= {quo[kfli_pkg::UW-2:0], 1'b0};
      end
      sq_rem <= {sq_rem[SqW:0], 1'b0};
      iter   <= iter - 1'b1;
    end else if (cmd.ease1) begin
      u      <= (span == '0) ? kfli_pkg::UW'(1 << kfli_pkg::FracBits) : quo;
      root   <= '0;
      sq_rem <= (SqW+2)'(((span == '0) ? kfli_pkg::UW'(1 << kfli_pkg::FracBits) : quo))
                << kfli_pkg::FracBits;
      iter   <= 6'(kfli_pkg::UW);
    end else if (cmd.ease2) begin
      sq <= sq_w >> kfli_pkg::FracBits;
    end else if (cmd.sqrt_step) begin
      // one result bit per step, from bit UW-1 down
      logic [SqW+1:0] rr;
      rr = ((SqW+2)'(root) << iter) + ((SqW+2)'(1) << ((iter - 1) * 2));
      if (sq_rem >= rr) begin
        sq_rem <= sq_rem - rr;
        root   <= root | ((kfli_pkg::UW+1)'(1) << (iter - 1));
      end
      iter <= iter - 1'b1;
    end
  end

  // ease select happens when blend registers ew; sq holds u*u>>F
  logic [kfli_pkg::UW-1:0] ew_sel;
  always_comb begin
    case (mode_e)
      kfli_pkg::EM_LINEAR: ew_sel = u;
      kfli_pkg::EM_SPLINE: ew_sel = kfli_pkg::UW'(sp_w >> kfli_pkg::FracBits);
      kfli_pkg::EM_ACCEL:  ew_sel = kfli_pkg::UW'(sq);
      default:             ew_sel = kfli_pkg::UW'(root);
    endcase
  end

  logic blend_ph;
  always_ff @(posedge clk) begin
    if (rst) blend_ph <= 1'b0;
    else     blend_ph <= cmd.blend;
  end

  always_ff @(posedge clk) begin
    if (cmd.blend) ew <= ew_sel;
    if (cmd.res_ins) begin
      res_status <= kfli_pkg::ST_OK;
      res_slot   <= 5'(scan_idx);
      res_x <= '0; res_y <= '0; res_z <= '0;
    end else if (cmd.res_full || cmd.res_miss) begin
      res_status <= cmd.res_full ? kfli_pkg::ST_FULL : kfli_pkg::ST_SPAN;
      res_slot   <= '0;
      res_x <= '0; res_y <= '0; res_z <= '0;
    end else if (blend_ph) begin
      res_status <= kfli_pkg::ST_OK;
      res_slot   <= '0;
      res_x <= blend_f(ent_s[63:32], pr_x);
      res_y <= blend_f(ent_s[95:64], pr_y);
      res_z <= blend_f(ent_s[127:96], pr_z);
    end
  end

endmodule

/* rtl/core/keyframe_list_interpolator.sv */
// ---------------------------------------------------------------------------
// keyframe_list_interpolator
// Time-sorted keyframe table with eased linear position interpolation.
// An insert scans for its slot and shifts the later keys up; a full table is refused.
// A query scans for its span; a hit then reads both keys, divides, eases and blends,
//   with the decelerate mode taking a square root in place of the squaring step.
// Throughput: one item at a time; the next is taken once the result is out.
// Reset: rst clears the key count and control; the table is not cleared.
// ---------------------------------------------------------------------------
module keyframe_list_interpolator (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [135:0]  s_tdata,  // key_or_query_time, pos_x, pos_y, pos_z, ease_mode
  input  logic          s_tuser,  // func
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata   // status, slot, out_x, out_y, out_z, zero pad
);

  kfli_pkg::cmd_t cmd;
  kfli_pkg::sts_t sts;
  logic           busy, done, start;
  logic [1:0]     r_status;
  logic [4:0]     r_slot;
  logic signed [31:0] r_x, r_y, r_z;

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;

  kfli_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(s_tuser),
    .out_free(!m_tvalid || m_tready), .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  kfli_dp u_dp (
    .clk(clk), .rst(rst), .load(start),
    .in_time(s_tdata[31:0]), .in_x(s_tdata[63:32]), .in_y(s_tdata[95:64]),
    .in_z(s_tdata[127:96]), .in_mode(s_tdata[129:128]),
    .cmd(cmd), .sts(sts),
    .res_status(r_status), .res_slot(r_slot), .res_x(r_x), .res_y(r_y), .res_z(r_z)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (done && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done && (!m_tvalid || m_tready))
      m_tdata <= {1'b0, r_z, r_y, r_x, r_slot, r_status};
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (done && !m_tvalid) |=> m_tvalid) else $error("result lost");

endmodule

/* tb/keyframe_list_interpolator_tb.sv */
// ---------------------------------------------------------------------------
// keyframe_list_interpolator_tb
// Streams keyframe inserts and position queries into the interpolator and
// checks every result against an in-bench predictor of the sorted key table,
// the fixed-point divide, easing and blend. Idle and stall rates vary by
// phase.
// ---------------------------------------------------------------------------
module keyframe_list_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        func;
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  mode;
  } item_t;

  typedef struct packed {
    logic [31:0] oz;
    logic [31:0] oy;
    logic [31:0] ox;
    logic [4:0]  slot;
    logic [1:0]  status;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;

  keyframe_list_interpolator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  item_t  pending[$];
  point_t expected_points[$];
  int     errors = 0;
  int     send_idle = 0;
  int     recv_idle = 0;
  longint cycles = 0;
  logic   s_tready_q = 1'b0;

  // predictor state
  logic signed [31:0] k_time[kfli_pkg::MaxKeys];
  logic signed [31:0] k_x[kfli_pkg::MaxKeys];
  logic signed [31:0] k_y[kfli_pkg::MaxKeys];
  logic signed [31:0] k_z[kfli_pkg::MaxKeys];
  logic [1:0]         k_mode[kfli_pkg::MaxKeys];
  int                 k_count = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] lerp_axis(longint a, longint b, longint e);
    longint p, q;
    p = (b - a) * e;
    if (p >= 0) q = p >>> kfli_pkg::FracBits;
    else q = -((-p + (64'sd1 << kfli_pkg::FracBits) - 1) >>> kfli_pkg::FracBits);
    return 32'(a + q);
  endfunction

  function automatic point_t apply_item(item_t it);
    point_t r;
    int pos, i, s;
    longint span, d, u, sq, e, one;
    r = '0;
    one = 64'sd1 << kfli_pkg::FracBits;
    if (it.func == kfli_pkg::FN_INSERT) begin
      if (k_count >= kfli_pkg::MaxKeys) begin
        r.status = kfli_pkg::ST_FULL;
        return r;
      end
      pos = k_count;
      for (i = 0; i < k_count; i++)
        if ($signed(it.t) < k_time[i]) begin
          pos = i;
          break;
        end
      for (i = k_count; i > pos; i--) begin
        k_time[i] = k_time[i-1]; k_x[i] = k_x[i-1]; k_y[i] = k_y[i-1];
        k_z[i] = k_z[i-1]; k_mode[i] = k_mode[i-1];
      end
      k_time[pos] = it.t; k_x[pos] = it.x; k_y[pos] = it.y;
      k_z[pos] = it.z; k_mode[pos] = it.mode;
      k_count++;
      r.status = kfli_pkg::ST_OK;
      r.slot = 5'(pos);
      return r;
    end
    for (i = 0; i < k_count; i++)
      if ($signed(it.t) < k_time[i]) begin
        if (i == 0) break;
        s = i - 1;
        span = longint'(k_time[i]) - longint'(k_time[s]);
        d = longint'($signed(it.t)) - longint'(k_time[s]);
        if (d < 0) d = 0;
        if (d > span) d = span;
        u = (span > 0) ? (d << kfli_pkg::FracBits) / span : one;
        sq = (u * u) >>> kfli_pkg::FracBits;
        case (k_mode[i])
          kfli_pkg::EM_SPLINE: e = (sq * (3 * one - 2 * u)) >>> kfli_pkg::FracBits;
          kfli_pkg::EM_ACCEL:  e = sq;
          kfli_pkg::EM_DECEL:  e = longint'(int_sqrt(longint'(u << kfli_pkg::FracBits)));
          default:             e = u;
        endcase
        r.ox = lerp_axis(k_x[s], k_x[i], e);
        r.oy = lerp_axis(k_y[s], k_y[i], e);
        r.oz = lerp_axis(k_z[s], k_z[i], e);
        return r;
      end
    r.status = kfli_pkg::ST_SPAN;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          item_t it;
          it = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= it.func;
          s_tdata  <= {6'b0, it.mode, it.z, it.y, it.x, it.t};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // accepted-transfer flags sampled at the rising edge
  always @(posedge clk) begin
    cycles++;
    s_tready_q <= (!rst && s_tvalid && s_tready);
    if (!rst && s_tvalid && s_tready) begin
      item_t it;
      it.func = s_tuser;
      {it.mode, it.z, it.y, it.x, it.t} = s_tdata[129:0];
      expected_points.push_back(apply_item(it));
    end
    if (!rst && m_tvalid && m_tready) begin
      point_t got, want;
      got = m_tdata[102:0];
      if (expected_points.size() == 0) begin
        $display("unexpected result %h at %0t", m_tdata, $realtime);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (got.status !== want.status) report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.slot !== want.slot) report_mismatch("slot", 32'(got.slot), 32'(want.slot));
        if (got.ox !== want.ox) report_mismatch("out_x", got.ox, want.ox);
        if (got.oy !== want.oy) report_mismatch("out_y", got.oy, want.oy);
        if (got.oz !== want.oz) report_mismatch("out_z", got.oz, want.oz);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("** keyframe_list_interpolator: FAILED **");
      $finish;
    end
  end

  function automatic item_t make_item(logic f, logic [31:0] t, logic [31:0] x,
                                      logic [31:0] y, logic [31:0] z, logic [1:0] m);
    item_t it;
    it.func = f; it.t = t; it.x = x; it.y = y; it.z = z; it.mode = m;
    return it;
  endfunction

  function automatic logic [31:0] rnd_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  // one random scene: reset-free clear is impossible, so sessions refill until full
  task automatic queue_random(int n);
    int i;
    logic [31:0] base, t;
    base = $urandom;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40)
        t = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(65536 * 64);
      else
        t = ($urandom_range(19) == 0) ? $urandom : base + $urandom_range(65536 * 70) - 65536*3;
      pending.push_back(make_item($urandom_range(99) < 40 ? kfli_pkg::FN_INSERT :
        kfli_pkg::FN_QUERY, t, rnd_pos(), rnd_pos(), rnd_pos(), 2'($urandom_range(3))));
    end
  endtask

  task automatic drain();
    while (pending.size() > 0 || expected_points.size() > 0 || s_tvalid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: empty table, extremes, every mode, equal times
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h0, 0, 0, 0, kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_INSERT, 32'h80000000, 32'h80000000,
                                32'h7fffffff, 32'h0, kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h80000000, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_INSERT, 32'h7fffffff, 32'h7fffffff,
                                32'h80000000, 32'hffffffff, kfli_pkg::EM_DECEL));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h80000000, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h00000000, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h7ffffffe, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h7fffffff, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_INSERT, 32'h00010000, 32'h00050000,
                                32'hfffb0000, 32'h1, kfli_pkg::EM_SPLINE));
    pending.push_back(make_item(kfli_pkg::FN_INSERT, 32'h00010000, 32'h12345678, 32'h0,
                                32'h0, kfli_pkg::EM_ACCEL));
    pending.push_back(make_item(kfli_pkg::FN_INSERT, 32'h00030000, 32'hfedcba98, 32'h1,
                                32'h7fffffff, kfli_pkg::EM_ACCEL));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h00008000, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h00010000, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h00020000, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h00050000, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    for (int i = 0; i < 12; i++)
      pending.push_back(make_item(kfli_pkg::FN_INSERT, 32'(i * 32'h8000), rnd_pos(),
                                  rnd_pos(), rnd_pos(), 2'(i)));
    pending.push_back(make_item(kfli_pkg::FN_QUERY, 32'h00014000, 0, 0, 0,
                                kfli_pkg::EM_LINEAR));
    for (p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 15 : (p == 1) ? 46 : 0;
      recv_idle = (p == 0) ? 46 : (p == 1) ? 15 : 0;
      queue_random(425);
      drain();
    end
    if (errors == 0) $display("** keyframe_list_interpolator: PASSED **");
    else $display("** keyframe_list_interpolator: FAILED **");
    $finish;
  end
endmodule
